### rtl/core/scan_code_to_char_decoder_defines.svh
// ----------------------------------------------------------------------------
// Scan code decoder assertion macros
// Shared assertion forms for the scan code decoder.
// ----------------------------------------------------------------------------
`ifndef SCAN_CODE_TO_CHAR_DECODER_DEFINES_SVH
`define SCAN_CODE_TO_CHAR_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scd: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scd: next-cycle implication failed");

`endif

### rtl/core/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Types, key tables and lookup shared by the scan code decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

    localparam int KEY_COUNT    = 56;
    localparam int LETTER_COUNT = 26;
    localparam int KEY_IDX_W    = 6;

    localparam logic [KEY_IDX_W-1:0] CAPS_INDEX  = 6'd50;
    localparam logic [KEY_IDX_W-1:0] TAB_INDEX   = 6'd51;
    localparam logic [KEY_IDX_W-1:0] FIRST_ARROW = 6'd52;

    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_LCTRL      = 8'h1D;
    localparam logic [7:0] SC_C          = 8'h2E;
    localparam logic [7:0] SC_D          = 8'h20;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_LCTRL_BRK  = 8'h9D;
    localparam logic [7:0] ARROW_CHAR    = 8'hFF;

    localparam logic [1:0] EV_CHAR = 2'd0;
    localparam logic [1:0] EV_EOF  = 2'd1;
    localparam logic [1:0] EV_KILL = 2'd2;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_ARROW,
        CMD_EOF,
        CMD_KILL
    } t_cmd_kind;

    // One queued command: what the back end has to produce.
    typedef struct packed {
        t_cmd_kind            kind;
        logic [KEY_IDX_W-1:0] idx;
        logic                 upper;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic                 hit;
        logic [KEY_IDX_W-1:0] idx;
    } t_key_hit;

    localparam logic [7:0] KEY_CODES [KEY_COUNT] = '{
        8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
        8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
        8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C,
        8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h33, 8'h34,
        8'h35, 8'h39, 8'h1C, 8'h0E, 8'h3A, 8'h0F, 8'h48, 8'h4B, 8'h4D, 8'h50
    };

    localparam logic [7:0] PLAIN_CHARS [KEY_COUNT] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
        8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
        8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h3B, 8'h27, 8'h60, 8'h5C, 8'h2C, 8'h2E,
        8'h2F, 8'h20, 8'h0A, 8'h08, 8'h63, 8'h09, 8'h75, 8'h6C, 8'h72, 8'h64
    };

    localparam logic [7:0] SHIFTED_CHARS [KEY_COUNT] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
        8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
        8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
        8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h3A, 8'h22, 8'h7E, 8'h7C, 8'h3C, 8'h3E,
        8'h3F, 8'h20, 8'h0A, 8'h08, 8'h63, 8'h09, 8'h75, 8'h6C, 8'h72, 8'h64
    };

    // Parallel compare against every table entry; codes are unique, so the
    // matches are one-hot and the index is a plain OR of the hits.
    function automatic t_key_hit key_lookup(input logic [7:0] code);
        t_key_hit r;
        r.hit = 1'b0;
        r.idx = '0;
        for (int i = 0; i < KEY_COUNT; i++) begin
            if (KEY_CODES[i] == code) begin
                r.hit = 1'b1;
                r.idx = r.idx | KEY_IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/scd_front.sv
// ----------------------------------------------------------------------------
// scd_front
// Accepts scan codes, tracks modifier flags and queues translate commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_scan_code,
    input  wire scd_pkg::t_q_status i_q_status,
    output logic                   o_push,
    output scd_pkg::t_cmd          o_cmd
);

    logic r_shift, n_shift;
    logic r_ctrl,  n_ctrl;
    logic r_caps,  n_caps;
    logic w_acc;
    scd_pkg::t_key_hit w_hit;

    assign o_in_ready = !i_q_status.full;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_hit      = scd_pkg::key_lookup(i_scan_code);

    always_comb begin
        n_shift     = r_shift;
        n_ctrl      = r_ctrl;
        n_caps      = r_caps;
        o_push      = 1'b0;
        o_cmd.kind  = scd_pkg::CMD_CHAR;
        o_cmd.idx   = w_hit.idx;
        // letters follow shift xor caps lock, everything else just shift
        o_cmd.upper = (w_hit.idx < scd_pkg::KEY_IDX_W'(scd_pkg::LETTER_COUNT)) ?
                      (r_shift ^ r_caps) : r_shift;
        if (w_acc) begin
            if (i_scan_code[7]) begin
                if (i_scan_code inside {scd_pkg::SC_RSHIFT_BRK, scd_pkg::SC_LSHIFT_BRK}) begin
                    n_shift = !r_shift;
                end else if (i_scan_code == scd_pkg::SC_LCTRL_BRK) begin
                    n_ctrl = !r_ctrl;
                end
            end else if (i_scan_code inside {scd_pkg::SC_RSHIFT, scd_pkg::SC_LSHIFT}) begin
                n_shift = !r_shift;
            end else if (i_scan_code == scd_pkg::SC_LCTRL) begin
                n_ctrl = !r_ctrl;
            end else if (w_hit.hit) begin
                if (r_ctrl && i_scan_code == scd_pkg::SC_C) begin
                    o_push     = 1'b1;
                    o_cmd.kind = scd_pkg::CMD_KILL;
                end else if (r_ctrl && i_scan_code == scd_pkg::SC_D) begin
                    o_push     = 1'b1;
                    o_cmd.kind = scd_pkg::CMD_EOF;
                end else if (w_hit.idx == scd_pkg::CAPS_INDEX) begin
                    n_caps = !r_caps;
                end else if (w_hit.idx == scd_pkg::TAB_INDEX && r_shift) begin
                    // shifted tab is swallowed
                end else if (w_hit.idx >= scd_pkg::FIRST_ARROW) begin
                    o_push     = 1'b1;
                    o_cmd.kind = scd_pkg::CMD_ARROW;
                end else begin
                    o_push = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_ctrl  <= 1'b0;
            r_caps  <= 1'b0;
        end else begin
            r_shift <= n_shift;
            r_ctrl  <= n_ctrl;
            r_caps  <= n_caps;
        end
    end

endmodule

`default_nettype wire

### rtl/core/scd_fifo.sv
// ----------------------------------------------------------------------------
// scd_fifo
// Short command queue between the decoder front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire scd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output scd_pkg::t_cmd      o_cmd,
    output scd_pkg::t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    scd_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_cmd          = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/core/scd_back.sv
// ----------------------------------------------------------------------------
// scd_back
// Turns queued commands into characters and holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire scd_pkg::t_cmd     i_cmd,
    input  wire scd_pkg::t_q_status i_q_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_character,
    output logic [1:0]             o_event_kind
);

    logic       r_valid, n_valid;
    logic [7:0] r_char,  n_char;
    logic [1:0] r_kind,  n_kind;

    // refill the output register whenever it is empty or being drained
    assign o_pop = !i_q_status.empty && (!r_valid || i_ready);

    always_comb begin
        n_char = 8'h00;
        n_kind = scd_pkg::EV_CHAR;
        case (i_cmd.kind)
            scd_pkg::CMD_CHAR: begin
                n_char = i_cmd.upper ? scd_pkg::SHIFTED_CHARS[i_cmd.idx] :
                                       scd_pkg::PLAIN_CHARS[i_cmd.idx];
            end
            scd_pkg::CMD_ARROW: begin
                n_char = scd_pkg::ARROW_CHAR;
            end
            scd_pkg::CMD_EOF: begin
                n_kind = scd_pkg::EV_EOF;
            end
            scd_pkg::CMD_KILL: begin
                n_kind = scd_pkg::EV_KILL;
            end
            default: begin
                n_kind = scd_pkg::EV_CHAR;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char <= n_char;
            r_kind <= n_kind;
        end
    end

    assign o_valid      = r_valid;
    assign o_character  = r_char;
    assign o_event_kind = r_kind;

endmodule

`default_nettype wire

### rtl/core/scan_code_to_char_decoder.sv
// ----------------------------------------------------------------------------
// scan_code_to_char_decoder
// Set-1 keyboard scan code to character decoder with modifier tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis) takes one scan code byte per transaction in tdata.
//   Master stream (m_axis) returns at most one result per scan code: the
//   character in tdata, the event kind in tuser (character, end of input,
//   terminate foreground task).
//   Modifier, release and caps lock codes and unmapped codes update the
//   shift/control/caps flags or are dropped and produce no transaction.
//   Throughput: one scan code per cycle while the queue is not full. The
//   front end classifies the code and updates the flags in the accept
//   cycle; the command is written into the queue at the accept edge and
//   is then popped into the output register, from which the result is
//   offered on m_axis.
//   When the receiver stalls, results pile up in the QUEUE_DEPTH-entry queue
//   plus the output register; s_axis tready drops once the queue is full.
//   Reset (synchronous, active low) clears all flags, empties the queue and
//   drops m_axis tvalid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "scan_code_to_char_decoder_defines.svh"

module scan_code_to_char_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] scan_code
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] character
    output logic [1:0]      o_m_axis_tuser    // [1:0] event_kind
);

    logic               w_push;
    logic               w_pop;
    logic               w_in_acc;
    logic               w_out_event;
    scd_pkg::t_cmd      w_push_cmd;
    scd_pkg::t_cmd      w_head_cmd;
    scd_pkg::t_q_status w_q_status;

    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_event = o_m_axis_tvalid && (o_m_axis_tuser != scd_pkg::EV_CHAR);

    scd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_scan_code (i_s_axis_tdata),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    scd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    scd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_head_cmd),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_character  (o_m_axis_tdata),
        .o_event_kind (o_m_axis_tuser)
    );

    `SCD_ASSERT_IMPL(a_release_no_push, i_clk, i_rst_n, (w_in_acc && i_s_axis_tdata[7]), (!w_push))
    `SCD_ASSERT_IMPL(a_push_not_full, i_clk, i_rst_n, (w_push), (!w_q_status.full))
    `SCD_ASSERT_IMPL(a_event_char_zero, i_clk, i_rst_n, (w_out_event), (o_m_axis_tdata == 8'h00))
    `SCD_ASSERT_NEXT(a_pop_fills_out, i_clk, i_rst_n, (w_pop), (o_m_axis_tvalid))

endmodule

`default_nettype wire
